// ===== hdl/tps_pkg.sv =====
package tps_pkg;

    // fixed field widths of the request and configuration port
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 8;
    localparam int STEP_W   = 16;

    localparam int PHASES   = 3;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UP      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DOWN    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TBL_WR  = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;
    localparam int FREQ_AT_STOP = 10;

    // duty update carried from the accept stage to the result stage
    typedef struct packed {
        logic advance;
        logic clear;
    } tps_duty_ctl_t;

endpackage

// ===== hdl/tps_table_ram.sv =====
module tps_table_ram #(
    parameter int DEPTH  = 42,
    parameter int DATA_W = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/three_phase_sine_pwm_sequencer.sv =====
// pipeline: two register stages; an accepted request waits in the first stage
//   and moves to the result register when it is free; one request per cycle
//   while the result is not stalled; the table read behind each tick sets the
//   two stages (three table copies, each with one registered read port)
// reset: aresetn synchronous active low; positions 0, 1/3 and 2/3 of the half
//   wave, polarities high, duties zero, stopped, frequency 10, step 1
// the sine table is not cleared and must be loaded before the drive runs
module three_phase_sine_pwm_sequencer
    import tps_pkg::*;
#(
    parameter int HALF_WAVE_STEPS = 42,
    parameter int DUTY_BITS       = 8,
    parameter int FREQ_BITS       = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration: frequency step
    input  logic                 cfg_wr_en,
    input  logic [STEP_W-1:0]    cfg_wr_data,

    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FUNC_W-1:0]    s_func,
    input  logic [INDEX_W-1:0]   s_table_index,
    input  logic [VALUE_W-1:0]   s_table_value,

    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DUTY_BITS-1:0] m_duty_a,
    output logic [DUTY_BITS-1:0] m_duty_b,
    output logic [DUTY_BITS-1:0] m_duty_c,
    output logic                 m_polarity_a,
    output logic                 m_polarity_b,
    output logic                 m_polarity_c,
    output logic                 m_running,
    output logic [FREQ_BITS-1:0] m_target_frequency
);

    localparam int POS_W = $clog2(HALF_WAVE_STEPS);
    // width wide enough for frequency plus step without overflow
    localparam int SUM_W = ((FREQ_BITS > STEP_W) ? FREQ_BITS : STEP_W) + 1;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(HALF_WAVE_STEPS - 1);
    localparam logic [POS_W-1:0] POS_B_INIT = POS_W'(HALF_WAVE_STEPS / 3);
    localparam logic [POS_W-1:0] POS_C_INIT = POS_W'((2 * HALF_WAVE_STEPS) / 3);
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(HALF_WAVE_STEPS);
    localparam logic [FREQ_BITS-1:0] FREQ_MAX  = {FREQ_BITS{1'b1}};
    localparam logic [FREQ_BITS-1:0] FREQ_STOP = FREQ_BITS'(FREQ_AT_STOP);

    // ------------------------------------------------------------------
    // handshake between the two stages
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg,  m_valid_next;
    logic s1_move;
    logic accept;

    // the first stage empties into the result register when that is free
    assign s1_move = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_move;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // architectural state, updated at the accept edge (the step on cfg_wr_en)
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]    step_reg;
    logic [POS_W-1:0]     pos_reg  [PHASES];
    logic [POS_W-1:0]     pos_next [PHASES];
    logic [POS_W-1:0]     pos_inc  [PHASES];
    logic [PHASES-1:0]    pol_reg, pol_next, pol_flip;
    logic                 run_reg, run_next;
    logic [FREQ_BITS-1:0] freq_reg, freq_next;

    logic [SUM_W-1:0]     freq_sum;
    logic [SUM_W-1:0]     freq_diff;
    logic                 is_tick_run;
    logic                 is_stop;
    logic                 tbl_wr;

    assign is_tick_run = (s_func == FUNC_TICK) && run_reg;
    assign is_stop     = (s_func == FUNC_TOGGLE) && run_reg;
    // writes beyond the half wave are dropped
    assign tbl_wr      = accept && (s_func == FUNC_TBL_WR) && (s_table_index < INDEX_LIMIT);

    assign freq_sum  = SUM_W'(freq_reg) + SUM_W'(step_reg);
    assign freq_diff = SUM_W'(freq_reg) - SUM_W'(step_reg);

    // next table position of each phase, wrapping at the end of the half wave
    always_comb begin
        for (int p = 0; p < PHASES; p++) begin
            if (pos_reg[p] >= POS_LAST) begin
                pos_inc[p]  = '0;
                pol_flip[p] = 1'b1;
            end else begin
                pos_inc[p]  = pos_reg[p] + POS_W'(1);
                pol_flip[p] = 1'b0;
            end
        end
    end

    always_comb begin
        pos_next  = pos_reg;
        pol_next  = pol_reg;
        run_next  = run_reg;
        freq_next = freq_reg;
        case (s_func)
            FUNC_TICK: begin
                if (run_reg) begin
                    pos_next = pos_inc;
                    pol_next = pol_reg ^ pol_flip;
                end
            end
            FUNC_UP: begin
                // saturate at the top of the frequency range
                if (freq_sum > SUM_W'(FREQ_MAX)) begin
                    freq_next = FREQ_MAX;
                end else begin
                    freq_next = FREQ_BITS'(freq_sum);
                end
            end
            FUNC_DOWN: begin
                // only while the frequency stays above the step
                if (SUM_W'(freq_reg) > SUM_W'(step_reg)) begin
                    freq_next = FREQ_BITS'(freq_diff);
                end
            end
            FUNC_TOGGLE: begin
                if (run_reg) begin
                    run_next  = 1'b0;
                    freq_next = FREQ_STOP;
                end else begin
                    run_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= STEP_RESET;
            pos_reg[0] <= '0;
            pos_reg[1] <= POS_B_INIT;
            pos_reg[2] <= POS_C_INIT;
            pol_reg    <= '1;
            run_reg    <= 1'b0;
            freq_reg   <= FREQ_STOP;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (accept) begin
                pos_reg  <= pos_next;
                pol_reg  <= pol_next;
                run_reg  <= run_next;
                freq_reg <= freq_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // sine table, one copy per phase so each phase has its own read port
    // ------------------------------------------------------------------
    logic [DUTY_BITS-1:0] tbl_rd_data [PHASES];
    logic                 tbl_rd_en;

    // read at the new positions in the same edge that commits them
    assign tbl_rd_en = accept && is_tick_run;

    for (genvar g = 0; g < PHASES; g++) begin : g_table
        tps_table_ram #(
            .DEPTH  (HALF_WAVE_STEPS),
            .DATA_W (DUTY_BITS)
        ) u_table (
            .aclk    (aclk),
            .wr_en   (tbl_wr),
            .wr_addr (s_table_index[POS_W-1:0]),
            .wr_data (DUTY_BITS'(s_table_value)),
            .rd_en   (tbl_rd_en),
            .rd_addr (pos_inc[g]),
            .rd_data (tbl_rd_data[g])
        );
    end

    // ------------------------------------------------------------------
    // first stage: snapshot of the state left by the request
    // ------------------------------------------------------------------
    tps_duty_ctl_t        s1_ctl_reg;
    logic [PHASES-1:0]    s1_pol_reg;
    logic                 s1_run_reg;
    logic [FREQ_BITS-1:0] s1_freq_reg;

    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg.advance <= is_tick_run;
            s1_ctl_reg.clear   <= is_stop;
            s1_pol_reg         <= pol_next;
            s1_run_reg         <= run_next;
            s1_freq_reg        <= freq_next;
        end
    end

    // ------------------------------------------------------------------
    // result stage: the held duties are the output register itself
    // ------------------------------------------------------------------
    logic [DUTY_BITS-1:0] duty_reg  [PHASES];
    logic [DUTY_BITS-1:0] duty_next [PHASES];
    logic [PHASES-1:0]    m_pol_reg;
    logic                 m_run_reg;
    logic [FREQ_BITS-1:0] m_freq_reg;

    always_comb begin
        for (int p = 0; p < PHASES; p++) begin
            if (s1_ctl_reg.clear) begin
                duty_next[p] = '0;
            end else if (s1_ctl_reg.advance) begin
                duty_next[p] = tbl_rd_data[p];
            end else begin
                duty_next[p] = duty_reg[p];
            end
        end
    end

    always_comb begin
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            duty_reg[0] <= '0;
            duty_reg[1] <= '0;
            duty_reg[2] <= '0;
            m_pol_reg   <= '1;
            m_run_reg   <= 1'b0;
            m_freq_reg  <= FREQ_STOP;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s1_move) begin
                duty_reg   <= duty_next;
                m_pol_reg  <= s1_pol_reg;
                m_run_reg  <= s1_run_reg;
                m_freq_reg <= s1_freq_reg;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_duty_a           = duty_reg[0];
    assign m_duty_b           = duty_reg[1];
    assign m_duty_c           = duty_reg[2];
    assign m_polarity_a       = m_pol_reg[0];
    assign m_polarity_b       = m_pol_reg[1];
    assign m_polarity_c       = m_pol_reg[2];
    assign m_running          = m_run_reg;
    assign m_target_frequency = m_freq_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a stalled result with a full first stage blocks new requests
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken while both stages are full");

    // an accepted request always lands in the first stage
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted request lost");

    // a stopped drive shows no duty
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_run_reg |-> (duty_reg[0] == '0 && duty_reg[1] == '0 && duty_reg[2] == '0))
        else $error("duty left over while stopped");

    // positions stay inside the half wave
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg[0] <= POS_LAST && pos_reg[1] <= POS_LAST && pos_reg[2] <= POS_LAST)
        else $error("table position out of range");

endmodule
